/* rtl/tla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tla_pkg;

    localparam int MAX_LINE_DEF = 64;

    localparam int CFG_W = 16;

    localparam logic [0:0] REG_MAX_LEN = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    localparam logic [6:0]  MAX_LEN_RST = 7'd64;
    localparam logic [15:0] TIMEOUT_RST = 16'd200;
    localparam logic [15:0] IDLE_SAT    = 16'hFFFF;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_DISC = 2'd2;
    localparam logic [1:0] ACT_CONN = 2'd3;

    localparam logic [1:0] CAUSE_TERM = 2'd0;
    localparam logic [1:0] CAUSE_IDLE = 2'd1;
    localparam logic [1:0] CAUSE_DISC = 2'd2;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_of_line;
        logic       line_truncated;
        logic [1:0] end_cause;
    } out_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic advance;
    } ctl_cmd_t;

    typedef struct packed {
        logic emit_start;
        logic at_last;
    } dp_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

endpackage

`default_nettype wire

/* rtl/text_line_assembler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Beat
// input     in_valid, in_stall, in_data      action and byte_value
// output    out_valid, out_stall, out_data   one character of a trimmed line
// config    cfg_we, cfg_index, cfg_data      register write, no handshake
//
// An item is accepted whenever the input is not stalled.
// An item that ends a nonempty trimmed line is followed by its N characters,
// each a line store read, then the beat; input stalls meanwhile.
// Output stall holds the current beat for as long as it lasts.
// Reset is immediate; the line store needs no clearing pass.

module text_line_assembler #(
    parameter int MAX_LINE = tla_pkg::MAX_LINE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [tla_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tla_pkg::in_t              in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tla_pkg::out_t                  out_data
);

    tla_pkg::ctl_cmd_t   cmd;
    tla_pkg::dp_status_t status;

    tla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tla_dpath #(
        .MAX_LINE (MAX_LINE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a line is emitted");

    a_last_releases_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_of_line) |=> !in_stall && !out_valid)
        else $error("line end did not return to capture");

    a_next_char_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.last_of_line) |=> !out_valid && in_stall)
        else $error("character fetch skipped");

    a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.end_cause == tla_pkg::CAUSE_TERM
                    || out_data.end_cause == tla_pkg::CAUSE_IDLE
                    || out_data.end_cause == tla_pkg::CAUSE_DISC))
        else $error("bad end cause");

endmodule

`default_nettype wire

/* rtl/tla_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tla_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tla_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire tla_pkg::dp_status_t status,
    output tla_pkg::ctl_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.emit_start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!out_stall)
                begin
                    state_next = status.at_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_SEND);
    assign cmd.accept  = in_valid && (state_reg == ST_IDLE);
    assign cmd.fetch   = (state_reg == ST_FETCH);
    assign cmd.advance = (state_reg == ST_SEND) && !out_stall;

endmodule

`default_nettype wire

/* rtl/tla_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tla_dpath #(
    parameter int MAX_LINE = tla_pkg::MAX_LINE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [tla_pkg::CFG_W-1:0] cfg_data,
    input  wire tla_pkg::in_t              in_data,
    output tla_pkg::out_t                  out_data,
    input  wire tla_pkg::ctl_cmd_t         cmd,
    output tla_pkg::dp_status_t            status
);

    localparam int AW = $clog2(MAX_LINE);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    logic [6:0]    max_len_reg;
    logic [15:0]   timeout_reg;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [15:0]   idle_reg, idle_next;
    logic          has_reg, has_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] stop_reg;
    logic          trunc_reg;
    logic [1:0]    cause_reg;

    logic          pending;
    logic [15:0]   idle_inc;
    logic [CW-1:0] limit;
    logic          end_req;
    logic          clr;
    logic [1:0]    cause_sel;
    logic          wr_en;
    logic          is_term;
    logic [7:0]    rd_char;

    assign pending  = (len_reg != '0) || ovf_reg;
    assign idle_inc = (idle_reg == tla_pkg::IDLE_SAT) ? idle_reg : idle_reg + 16'd1;
    assign limit    = (CW'(max_len_reg) < CW'(MAX_LINE)) ? CW'(max_len_reg) : CW'(MAX_LINE);
    assign is_term  = (in_data.byte_value == tla_pkg::CHAR_CR)
                   || (in_data.byte_value == tla_pkg::CHAR_LF);

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idle_next  = idle_reg;
        has_next   = has_reg;
        first_next = first_reg;
        last_next  = last_reg;
        end_req    = 1'b0;
        clr        = 1'b0;
        cause_sel  = tla_pkg::CAUSE_TERM;
        wr_en      = 1'b0;
        if (cmd.accept)
        begin
            case (in_data.action)
                tla_pkg::ACT_BYTE:
                begin
                    idle_next = '0;
                    if (is_term)
                    begin
                        end_req   = 1'b1;
                        cause_sel = tla_pkg::CAUSE_TERM;
                    end
                    else if (!ovf_reg)
                    begin
                        if (CW'(len_reg) >= limit)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LW'(1);
                            if (!tla_pkg::is_blank(in_data.byte_value))
                            begin
                                last_next = len_reg[AW-1:0];
                                if (!has_reg)
                                begin
                                    first_next = len_reg[AW-1:0];
                                    has_next   = 1'b1;
                                end
                            end
                        end
                    end
                end
                tla_pkg::ACT_TICK:
                begin
                    if (pending)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc > timeout_reg)
                        begin
                            end_req   = 1'b1;
                            cause_sel = tla_pkg::CAUSE_IDLE;
                        end
                    end
                end
                tla_pkg::ACT_DISC:
                begin
                    end_req   = 1'b1;
                    cause_sel = tla_pkg::CAUSE_DISC;
                    clr       = 1'b1;
                end
                default:
                begin
                    clr = 1'b1;
                end
            endcase
        end
        if (end_req && pending)
        begin
            clr = 1'b1;
        end
        if (clr)
        begin
            len_next  = '0;
            ovf_next  = 1'b0;
            idle_next = '0;
            has_next  = 1'b0;
        end
    end

    assign status.emit_start = end_req && pending && has_reg;
    assign status.at_last    = (idx_reg == stop_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tla_pkg::MAX_LEN_RST;
            timeout_reg <= tla_pkg::TIMEOUT_RST;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            idle_reg    <= '0;
            has_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tla_pkg::REG_MAX_LEN: max_len_reg <= cfg_data[6:0];
                    tla_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                    default:              timeout_reg <= timeout_reg;
                endcase
            end
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            idle_reg <= idle_next;
            has_reg  <= has_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        if (status.emit_start)
        begin
            idx_reg   <= first_reg;
            stop_reg  <= last_reg;
            trunc_reg <= ovf_reg;
            cause_reg <= cause_sel;
        end
        else if (cmd.advance && !status.at_last)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    tla_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (len_reg[AW-1:0]),
        .wdata (in_data.byte_value),
        .re    (cmd.fetch),
        .raddr (idx_reg),
        .rdata (rd_char)
    );

    assign out_data.character      = rd_char;
    assign out_data.last_of_line   = status.at_last;
    assign out_data.line_truncated = trunc_reg;
    assign out_data.end_cause      = cause_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import tla_pkg::*;

    localparam int CYCLE_LIMIT = 100_000;

    class line_tracker;
        logic [6:0]  max_len;
        logic [15:0] timeout;
        logic [7:0]  store [MAX_LINE_DEF];
        logic [6:0]  len;
        logic        ovf;
        logic [15:0] idle_ticks;
        out_t        char_queue [$];
        int          errors;
        int          beats_in;
        int          chars_checked;
        int          lines_by_cause [3];
        int          truncated_lines;

        function new();
            max_len = MAX_LEN_RST;
            timeout = TIMEOUT_RST;
            drop_capture();
            errors = 0;
            beats_in = 0;
            chars_checked = 0;
            lines_by_cause = '{default: 0};
            truncated_lines = 0;
        endfunction

        function void drop_capture();
            len = '0;
            ovf = 1'b0;
            idle_ticks = '0;
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == CHAR_SP || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
        endfunction

        function void set_reg(logic [0:0] idx, logic [15:0] val);
            if (idx == REG_MAX_LEN)
                max_len = val[6:0];
            else
                timeout = val;
        endfunction

        function void close_line(logic [1:0] cause);
            int   first;
            int   stop;
            logic trunc;
            out_t c;
            if (len == 0 && !ovf)
                return;
            first = 0;
            stop = len;
            trunc = ovf;
            drop_capture();
            while (first < stop && blank_char(store[first]))
                first++;
            while (stop > first && blank_char(store[stop - 1]))
                stop--;
            if (stop > first)
            begin
                lines_by_cause[cause]++;
                if (trunc)
                    truncated_lines++;
            end
            for (int i = first; i < stop; i++)
            begin
                c.character = store[i];
                c.last_of_line = (i == stop - 1);
                c.line_truncated = trunc;
                c.end_cause = cause;
                char_queue.push_back(c);
            end
        endfunction

        function void absorb_beat(in_t b);
            int lim;
            beats_in++;
            case (b.action)
                ACT_BYTE:
                begin
                    idle_ticks = '0;
                    if (b.byte_value == CHAR_CR || b.byte_value == CHAR_LF)
                        close_line(CAUSE_TERM);
                    else if (!ovf)
                    begin
                        lim = (max_len < MAX_LINE_DEF) ? int'(max_len) : MAX_LINE_DEF;
                        if (len >= lim)
                            ovf = 1'b1;
                        else
                        begin
                            store[len] = b.byte_value;
                            len++;
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (len != 0 || ovf)
                    begin
                        if (idle_ticks != IDLE_SAT)
                            idle_ticks++;
                        if (idle_ticks > timeout)
                            close_line(CAUSE_IDLE);
                    end
                end
                ACT_DISC:
                begin
                    close_line(CAUSE_DISC);
                    drop_capture();
                end
                default:
                    drop_capture();
            endcase
        endfunction

        function void check_char(out_t got);
            out_t want;
            if (char_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: char %h last %b trunc %b cause %0d",
                             got.character, got.last_of_line, got.line_truncated,
                             got.end_cause);
                return;
            end
            want = char_queue.pop_front();
            chars_checked++;
            if (got.character !== want.character || got.last_of_line !== want.last_of_line ||
                got.line_truncated !== want.line_truncated || got.end_cause !== want.end_cause)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected char %h last %b trunc %b cause %0d",
                             want.character, want.last_of_line, want.line_truncated,
                             want.end_cause);
                    $display("          got char %h last %b trunc %b cause %0d",
                             got.character, got.last_of_line, got.line_truncated,
                             got.end_cause);
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;

    line_tracker tracker = new;

    int burst_left = 0;
    int items_sent = 0;
    int cur_max = 64;
    int cur_timeout = 200;
    int cycle_count = 0;
    int stall_mode = 0;
    int stall_span = 0;

    text_line_assembler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("text_line_assembler test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.absorb_beat(in_data);
            if (out_valid && !out_stall)
                tracker.check_char(out_data);
        end
    end

    // receiver: switch stall pattern after a random span
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic push_beat(input logic [1:0] act, input logic [7:0] value);
        in_t beat;
        int  gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        beat.action = act;
        beat.byte_value = value;
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every expected beat is out and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (tracker.char_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(input int max_chars, input int ticks);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_LEN;
        cfg_data <= 16'(max_chars);
        @(posedge clk);
        tracker.set_reg(REG_MAX_LEN, 16'(max_chars));
        cfg_index <= REG_TIMEOUT;
        cfg_data <= 16'(ticks);
        @(posedge clk);
        tracker.set_reg(REG_TIMEOUT, 16'(ticks));
        cfg_we <= 1'b0;
        cur_max = max_chars;
        cur_timeout = ticks;
    endtask

    task automatic send_line();
        int         n;
        int         r;
        logic [7:0] b;
        if (cur_max <= 17 && $urandom_range(0, 3) == 0)
            n = cur_max - 1 + int'($urandom_range(0, 3));
        else
            n = $urandom_range(0, 8);
        if (n < 0)
            n = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: b = CHAR_SP;
                    1: b = CHAR_TAB;
                    2: b = CHAR_VT;
                    default: b = CHAR_FF;
                endcase
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_CR || b == CHAR_LF)
                    b = CHAR_SP;
            end
            if ($urandom_range(0, 9) == 0)
                push_beat(ACT_TICK, 8'($urandom_range(0, 255)));
            push_beat(ACT_BYTE, b);
        end
        r = $urandom_range(0, 9);
        if (r < 4)
            push_beat(ACT_BYTE, r[0] ? CHAR_CR : CHAR_LF);
        else if (r < 6)
        begin
            if (cur_timeout <= 20)
                repeat (cur_timeout + 1) push_beat(ACT_TICK, 8'($urandom_range(0, 255)));
            else
                push_beat(ACT_BYTE, CHAR_LF);
        end
        else if (r < 8)
            push_beat(ACT_DISC, 8'($urandom_range(0, 255)));
        else if (r == 8)
            push_beat(ACT_CONN, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int max_chars, input int ticks);
        int stop_at;
        set_limits(max_chars, ticks);
        stop_at = items_sent + 8;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                send_line();
            else
                push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAX_LEN;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick and terminator with nothing pending
        push_beat(ACT_TICK, 8'hFF);
        push_beat(ACT_BYTE, CHAR_LF);
        // blanks around extreme byte values
        push_beat(ACT_BYTE, CHAR_TAB);
        push_beat(ACT_BYTE, 8'h00);
        push_beat(ACT_BYTE, CHAR_SP);
        push_beat(ACT_BYTE, 8'hFF);
        push_beat(ACT_BYTE, CHAR_VT);
        push_beat(ACT_BYTE, CHAR_FF);
        push_beat(ACT_BYTE, CHAR_CR);
        // blank-only line
        push_beat(ACT_BYTE, CHAR_SP);
        push_beat(ACT_BYTE, CHAR_TAB);
        push_beat(ACT_BYTE, CHAR_LF);
        // disconnect with and without a pending line
        push_beat(ACT_BYTE, 8'h78);
        push_beat(ACT_DISC, 8'h00);
        push_beat(ACT_DISC, 8'h00);
        // connect drops the capture
        push_beat(ACT_BYTE, 8'h79);
        push_beat(ACT_CONN, 8'h00);
        push_beat(ACT_BYTE, CHAR_LF);
        // one-character limit, zero timeout
        set_limits(1, 0);
        push_beat(ACT_BYTE, 8'h61);
        push_beat(ACT_BYTE, 8'h62);
        push_beat(ACT_TICK, 8'h00);
        // zero limit: truncated but empty
        set_limits(0, 200);
        push_beat(ACT_BYTE, 8'h6D);
        push_beat(ACT_BYTE, CHAR_SP);
        push_beat(ACT_BYTE, CHAR_LF);

        // largest timeout never fires
        set_limits(64, 65535);
        push_beat(ACT_BYTE, 8'h53);
        repeat (3) push_beat(ACT_TICK, 8'($urandom_range(0, 255)));
        push_beat(ACT_BYTE, CHAR_LF);

        run_phase(64, 200);
        run_phase(8, 3);
        run_phase(1, 0);
        run_phase(0, 4);
        run_phase(64, 65535);
        run_phase(17, 1);
        run_phase(3, 10);
        run_phase(64, 2);

        settle();
        if (tracker.char_queue.size() != 0)
        begin
            tracker.errors += tracker.char_queue.size();
            $display("%0d expected characters never arrived", tracker.char_queue.size());
        end
        $display("Covered %0d input beats and %0d checked characters in directed and random runs.",
                 tracker.beats_in, tracker.chars_checked);
        $display("Lines closed by terminator %0d, idle %0d, disconnect %0d; %0d truncated.",
                 tracker.lines_by_cause[CAUSE_TERM], tracker.lines_by_cause[CAUSE_IDLE],
                 tracker.lines_by_cause[CAUSE_DISC], tracker.truncated_lines);
        if (tracker.errors == 0)
        begin
            $display("text_line_assembler test passed");
        end
        else
        begin
            $display("%0d mismatches", tracker.errors);
            $display("text_line_assembler test failed");
        end
        $finish;
    end

endmodule
